// ===== hdl/cpbd_pkg.sv =====
package cpbd_pkg;

	localparam int TIME_W   = 32;
	localparam int CHARGE_W = 24;
	localparam int CH_W     = 11;
	localparam int DT_W     = 28;
	localparam int ADC_W    = 12;
	localparam int LEV_W    = 13;
	localparam int DEAD_W   = 20;
	localparam int MARGIN_W = 24;
	localparam int RCNT_W   = 4;
	localparam int PROD_W   = CHARGE_W + LEV_W;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 64;
	localparam logic [LEV_W-1:0] LEV_MAX = 13'd4096;

	typedef enum logic [1:0] {
		REQ_ADD  = 2'd0,
		REQ_READ = 2'd1,
		REQ_SET  = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_DIGI   = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_MERGED   = 2'd0,
		ST_INSERTED = 2'd1,
		ST_DEAD     = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_DYN_RANGE = 3'd1,
		CFG_ADC_LEVELS = 3'd2,
		CFG_DEAD_TIME = 3'd3,
		CFG_MARGIN    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0]   ptime;
		logic [CHARGE_W-1:0] charge;
	} slot_t;

	typedef struct packed {
		logic                start;
		logic [CHARGE_W-1:0] charge;
	} adc_req_t;

endpackage

// ===== hdl/channel_pulse_buffer_digitizer_unit.sv =====
// Per-channel pulse store with digitizer. Channel state (fill count, dead mark) sits in a
// table with one write and one read port and the pulses in a slot memory of CHANNELS x
// SLOTS entries; each item reads its channel, copies the n stored pulses into a local row,
// updates the row and writes changed slots back one per cycle. One item is worked at a
// time; an insert or a merge writes its changed slots back, a pulse on a full or dead
// channel is dropped, a set writes the dead mark, and a readout sends a digi for each
// removed pulse at or above the threshold, coded by the ADC unit (one multiply step and a
// 13-bit restoring division). After reset a sweep over all CHANNELS entries clears the
// channel table; no item is taken until it ends, configuration writes are taken at any time.
module channel_pulse_buffer_digitizer_unit #(
	parameter int CHANNELS = 2048,
	parameter int SLOTS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// channel, pulse_time, charge, read_all, dead_mark
	input  logic [cpbd_pkg::IN_W-1:0]         s_tdata,
	// req_type
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, out_channel, digi_time, adc, removed_count
	output logic [cpbd_pkg::OUT_W-1:0]        m_tdata,
	// kind
	output logic [1:0]                        m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cpbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cpbd_pkg::CFG_W-1:0]        cfg_data
);
	import cpbd_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(SLOTS + 1);
	localparam int BD = 2 ** SW;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_LOAD, S_ADD, S_SCAN, S_DIGI_GO, S_DIGI_WAIT,
		S_DIGI_OUT, S_SHIFT, S_WB, S_RESP
	} state_t;

	state_t               state_q;
	logic [CHARGE_W-1:0]  thr_q;
	logic [CHARGE_W-1:0]  dr_q;
	logic [LEV_W-1:0]     lev_q;
	logic [DEAD_W-1:0]    dt_q;
	logic [MARGIN_W-1:0]  rm_q;

	req_t                 req_q;
	logic [CH_W-1:0]      chn_q;
	logic [CW-1:0]        ca_q;
	logic [TIME_W-1:0]    t_q;
	logic [CHARGE_W-1:0]  q_q;
	logic                 all_q;
	logic                 mark_q;
	logic                 valid_q;
	logic [NW-1:0]        idx_q;
	logic [NW-1:0]        cnt_q;
	logic                 dead_q;
	logic [NW-1:0]        wb_hi_q;
	logic [NW-1:0]        rem_q;
	kind_t                res_kind_q;
	status_t              res_status_q;
	logic [RCNT_W-1:0]    res_cnt_q;
	slot_t                buf_q [BD];

	logic                 clr_q;
	logic [CW-1:0]        clr_addr_q;
	logic [NW:0]          chan_mem [CHANNELS];
	logic [NW:0]          chan_rd_q;
	logic                 ch_we;
	logic [CW-1:0]        ch_waddr;
	logic [NW:0]          ch_wdata;
	logic                 fsm_ch_we;
	logic [NW:0]          fsm_ch_wdata;
	logic [CW-1:0]        ch_raddr;

	logic [CH_W-1:0]      in_ch;
	req_t                 in_req;
	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	slot_t                sel;
	slot_t                rdata;
	logic [CW+SW-1:0]     slot_addr;
	logic [NW-1:0]        idx_m1;

	logic [BD-1:0]        hit;
	logic [BD-1:0]        le;
	logic [BD-1:0]        rle;
	logic                 any_hit;
	logic                 full;
	logic [SW-1:0]        m_idx;
	logic [NW-1:0]        pos;
	logic [NW-1:0]        rcnt;
	logic [TIME_W-1:0]    diff;
	logic [TIME_W-1:0]    limit;
	logic [MARGIN_W:0]    sub;
	logic                 neg;
	logic [CHARGE_W:0]    msum;
	slot_t                nbuf [BD];
	slot_t                mbuf [BD];
	slot_t                sbuf [BD];
	logic [4:0]           rem5;
	logic [RCNT_W-1:0]    rem_sat;
	logic [TIME_W:0]      tsum;
	logic [DT_W-1:0]      dtime;

	adc_req_t             adc_req;
	logic                 adc_done;
	logic [ADC_W-1:0]     adc_code;

	kind_t                o_kind;
	status_t              o_status;
	logic [DT_W-1:0]      o_time;
	logic [ADC_W-1:0]     o_adc;
	logic [RCNT_W-1:0]    o_cnt;
	logic                 o_last;

	assign in_ch     = s_tdata[10:0];
	assign in_req    = req_t'(s_tuser);
	assign s_tready  = (state_q == S_IDLE) && !clr_q;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;
	assign out_load  = out_free && ((state_q == S_DIGI_OUT) || (state_q == S_RESP));
	assign sel       = buf_q[idx_q[SW-1:0]];
	assign idx_m1    = idx_q - NW'(1);
	assign slot_addr = {ca_q, idx_q[SW-1:0]};
	assign ch_raddr  = (state_q == S_IDLE) ? CW'(in_ch) : ca_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= CHARGE_W'(4000);
			dr_q  <= CHARGE_W'(75000);
			lev_q <= LEV_W'(32);
			dt_q  <= '0;
			rm_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD:  thr_q <= cfg_data[CHARGE_W-1:0];
				CFG_DYN_RANGE:  dr_q  <= cfg_data[CHARGE_W-1:0];
				CFG_ADC_LEVELS: lev_q <= cfg_data[LEV_W-1:0];
				CFG_DEAD_TIME:  dt_q  <= cfg_data[DEAD_W-1:0];
				CFG_MARGIN:     rm_q  <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == CW'(CHANNELS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + CW'(1);
			end
		end
	end

	assign ch_we    = clr_q || fsm_ch_we;
	assign ch_waddr = clr_q ? clr_addr_q : ca_q;
	assign ch_wdata = clr_q ? '0 : fsm_ch_wdata;

	always_ff @(posedge clk) begin
		if (ch_we) begin
			chan_mem[ch_waddr] <= ch_wdata;
		end
		chan_rd_q <= chan_mem[ch_raddr];
	end

	cpbd_slot_ram #(
		.AW(CW + SW)
	) u_slot_ram (
		.clk  (clk),
		.we   (state_q == S_WB),
		.waddr(slot_addr),
		.wdata(sel),
		.raddr(slot_addr),
		.rdata(rdata)
	);

	assign adc_req.start  = (state_q == S_DIGI_GO) && (idx_q != rem_q) &&
		(sel.charge >= thr_q);
	assign adc_req.charge = sel.charge;

	cpbd_adc u_adc (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (adc_req),
		.threshold    (thr_q),
		.dynamic_range(dr_q),
		.adc_levels   (lev_q),
		.done         (adc_done),
		.code         (adc_code)
	);

	always_comb begin
		logic live;
		live = 1'b0;
		hit   = '0;
		le    = '0;
		rle   = '0;
		m_idx = '0;
		pos   = '0;
		rcnt  = '0;
		diff  = '0;
		msum  = '0;
		sub   = (MARGIN_W+1)'(rm_q) + (MARGIN_W+1)'(dt_q);
		neg   = TIME_W'(sub) > t_q;
		limit = t_q - TIME_W'(sub);
		for (int i = 0; i < BD; i++) begin
			live   = NW'(i) < cnt_q;
			diff   = (buf_q[i].ptime > t_q) ? buf_q[i].ptime - t_q : t_q - buf_q[i].ptime;
			hit[i] = live && (diff < TIME_W'(dt_q));
			le[i]  = live && (buf_q[i].ptime <= t_q);
			rle[i] = live && (buf_q[i].ptime <= limit);
		end
		for (int i = BD - 1; i >= 0; i--) begin
			if (hit[i]) begin
				m_idx = SW'(i);
			end
		end
		for (int i = 0; i < BD; i++) begin
			pos  = pos + NW'(le[i]);
			rcnt = rcnt + NW'(rle[i]);
		end
		if (all_q) begin
			rcnt = cnt_q;
		end else if (neg) begin
			rcnt = '0;
		end
		any_hit = |hit;
		full    = cnt_q >= NW'(SLOTS);
		for (int i = 0; i < BD; i++) begin
			if (NW'(i) < pos) begin
				nbuf[i] = buf_q[i];
			end else if (NW'(i) == pos) begin
				nbuf[i] = '{ptime: t_q, charge: q_q};
			end else begin
				nbuf[i] = buf_q[SW'(i - 1)];
			end
			mbuf[i] = buf_q[i];
			if (SW'(i) == m_idx) begin
				msum = (CHARGE_W+1)'(buf_q[i].charge) + (CHARGE_W+1)'(q_q);
				mbuf[i].charge = msum[CHARGE_W] ? '1 : msum[CHARGE_W-1:0];
				if (t_q < buf_q[i].ptime) begin
					mbuf[i].ptime = t_q;
				end
			end
			sbuf[i] = buf_q[i];
			for (int j = 0; j < BD; j++) begin
				if (i + int'(rem_q) == j) begin
					sbuf[i] = buf_q[j];
				end
			end
		end
		rem5    = 5'(rem_q);
		rem_sat = (rem5 > 5'd15) ? 4'hF : rem5[3:0];
		tsum    = (TIME_W+1)'(sel.ptime) + (TIME_W+1)'(8);
		dtime   = tsum[TIME_W] ? '1 : tsum[TIME_W-1:4];
	end

	always_comb begin
		fsm_ch_we    = 1'b0;
		fsm_ch_wdata = chan_rd_q;
		unique case (state_q)
			S_LOOK: begin
				fsm_ch_we    = (req_q == REQ_SET) && valid_q;
				fsm_ch_wdata = {mark_q, chan_rd_q[NW-1:0]};
			end
			S_ADD: begin
				fsm_ch_we    = !any_hit && !full;
				fsm_ch_wdata = {1'b0, cnt_q + NW'(1)};
			end
			S_SHIFT: begin
				fsm_ch_we    = rem_q != '0;
				fsm_ch_wdata = {dead_q, cnt_q - rem_q};
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == S_DIGI_OUT) begin
			o_kind   = KIND_DIGI;
			o_status = ST_MERGED;
			o_time   = dtime;
			o_adc    = adc_code;
			o_cnt    = '0;
			o_last   = 1'b0;
		end else begin
			o_kind   = res_kind_q;
			o_status = res_status_q;
			o_time   = '0;
			o_adc    = '0;
			o_cnt    = res_cnt_q;
			o_last   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_LOAD) && (idx_q != '0)) begin
			buf_q[idx_m1[SW-1:0]] <= rdata;
		end else if (state_q == S_ADD) begin
			buf_q <= any_hit ? mbuf : nbuf;
		end else if (state_q == S_SHIFT) begin
			buf_q <= sbuf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_NONE;
			chn_q        <= '0;
			ca_q         <= '0;
			t_q          <= '0;
			q_q          <= '0;
			all_q        <= 1'b0;
			mark_q       <= 1'b0;
			valid_q      <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
			dead_q       <= 1'b0;
			wb_hi_q      <= '0;
			rem_q        <= '0;
			res_kind_q   <= KIND_STATUS;
			res_status_q <= ST_MERGED;
			res_cnt_q    <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
			m_tlast      <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {7'b0, o_cnt, o_adc, o_time, chn_q, o_status};
				m_tuser  <= o_kind;
				m_tlast  <= o_last;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						req_q   <= in_req;
						chn_q   <= in_ch;
						ca_q    <= CW'(in_ch);
						t_q     <= s_tdata[42:11];
						q_q     <= s_tdata[66:43];
						all_q   <= s_tdata[67];
						mark_q  <= s_tdata[68];
						valid_q <= 32'(in_ch) < 32'(CHANNELS);
						if (in_req != REQ_NONE) begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					cnt_q        <= chan_rd_q[NW-1:0];
					dead_q       <= chan_rd_q[NW];
					idx_q        <= '0;
					res_status_q <= ST_MERGED;
					res_cnt_q    <= '0;
					unique case (req_q)
						REQ_ADD: begin
							res_kind_q <= KIND_STATUS;
							if (!valid_q || chan_rd_q[NW]) begin
								res_status_q <= ST_DEAD;
								state_q      <= S_RESP;
							end else begin
								state_q <= S_LOAD;
							end
						end
						REQ_READ: begin
							res_kind_q <= KIND_DONE;
							state_q    <= valid_q ? S_LOAD : S_RESP;
						end
						REQ_SET: begin
							res_kind_q <= KIND_STATUS;
							state_q    <= S_RESP;
						end
						REQ_NONE: state_q <= S_IDLE;
					endcase
				end
				S_LOAD: begin
					if (idx_q == cnt_q) begin
						state_q <= (req_q == REQ_ADD) ? S_ADD : S_SCAN;
					end else begin
						idx_q <= idx_q + NW'(1);
					end
				end
				S_ADD: begin
					if (any_hit) begin
						res_status_q <= ST_MERGED;
						idx_q        <= NW'(m_idx);
						wb_hi_q      <= NW'(m_idx) + NW'(1);
						state_q      <= S_WB;
					end else if (full) begin
						res_status_q <= ST_FULL;
						state_q      <= S_RESP;
					end else begin
						res_status_q <= ST_INSERTED;
						idx_q        <= pos;
						wb_hi_q      <= cnt_q + NW'(1);
						state_q      <= S_WB;
					end
				end
				S_SCAN: begin
					rem_q   <= rcnt;
					idx_q   <= '0;
					state_q <= S_DIGI_GO;
				end
				S_DIGI_GO: begin
					if (idx_q == rem_q) begin
						state_q <= S_SHIFT;
					end else if (sel.charge >= thr_q) begin
						state_q <= S_DIGI_WAIT;
					end else begin
						idx_q <= idx_q + NW'(1);
					end
				end
				S_DIGI_WAIT: begin
					if (adc_done) begin
						state_q <= S_DIGI_OUT;
					end
				end
				S_DIGI_OUT: begin
					if (out_free) begin
						idx_q   <= idx_q + NW'(1);
						state_q <= S_DIGI_GO;
					end
				end
				S_SHIFT: begin
					res_cnt_q <= rem_sat;
					idx_q     <= '0;
					wb_hi_q   <= cnt_q - rem_q;
					state_q   <= ((rem_q != '0) && (cnt_q != rem_q)) ? S_WB : S_RESP;
				end
				S_WB: begin
					if (idx_q + NW'(1) == wb_hi_q) begin
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + NW'(1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded over a beat not yet taken");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_req != REQ_NONE)) |=> (state_q == S_LOOK))
		else $error("accepted request did not start channel lookup");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_LOOK) && !clr_q) |-> (chan_rd_q[NW-1:0] <= NW'(SLOTS)))
		else $error("channel fill count above slot count");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGI_GO) |-> (rem_q <= cnt_q))
		else $error("readout removes more pulses than stored");
`endif

endmodule

// ===== hdl/cpbd_slot_ram.sv =====
module cpbd_slot_ram #(
	parameter int AW = 14
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  cpbd_pkg::slot_t wdata,
	input  logic [AW-1:0]   raddr,
	output cpbd_pkg::slot_t rdata
);
	import cpbd_pkg::*;

	slot_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/cpbd_adc.sv =====
module cpbd_adc (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cpbd_pkg::adc_req_t               req,
	input  logic [cpbd_pkg::CHARGE_W-1:0]    threshold,
	input  logic [cpbd_pkg::CHARGE_W-1:0]    dynamic_range,
	input  logic [cpbd_pkg::LEV_W-1:0]       adc_levels,
	output logic                             done,
	output logic [cpbd_pkg::ADC_W-1:0]       code
);
	import cpbd_pkg::*;

	typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} astate_t;

	astate_t             state_q;
	logic [CHARGE_W-1:0] diff_q;
	logic                big_q;
	logic                zero_q;
	logic [LEV_W-1:0]    lev_q;
	logic [PROD_W-1:0]   rem_q;
	logic [LEV_W-1:0]    quot_q;
	logic [3:0]          bit_q;
	logic [LEV_W-1:0]    lev;
	logic [ADC_W-1:0]    levm1;
	logic [PROD_W-1:0]   dshift;
	logic                ge;

	always_comb begin
		if (adc_levels == '0) begin
			lev = LEV_W'(1);
		end else if (adc_levels > LEV_MAX) begin
			lev = LEV_MAX;
		end else begin
			lev = adc_levels;
		end
		levm1  = ADC_W'(lev_q - LEV_W'(1));
		dshift = PROD_W'(dynamic_range) << bit_q;
		ge     = rem_q >= dshift;
		if (big_q) begin
			code = levm1;
		end else if (zero_q) begin
			code = '0;
		end else if (quot_q > {1'b0, levm1}) begin
			code = levm1;
		end else begin
			code = quot_q[ADC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done    <= 1'b0;
			diff_q  <= '0;
			big_q   <= 1'b0;
			zero_q  <= 1'b0;
			lev_q   <= LEV_W'(1);
			rem_q   <= '0;
			quot_q  <= '0;
			bit_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						diff_q  <= req.charge - threshold;
						big_q   <= req.charge > dynamic_range;
						zero_q  <= dynamic_range == '0;
						lev_q   <= lev;
						state_q <= A_MUL;
					end
				end
				A_MUL: begin
					rem_q   <= PROD_W'(diff_q) * PROD_W'(lev_q);
					quot_q  <= '0;
					bit_q   <= 4'(LEV_W - 1);
					state_q <= A_DIV;
				end
				A_DIV: begin
					if (ge) begin
						rem_q         <= rem_q - dshift;
						quot_q[bit_q] <= 1'b1;
					end
					if (bit_q == '0) begin
						done    <= 1'b1;
						state_q <= A_IDLE;
					end else begin
						bit_q <= bit_q - 4'd1;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule
